// ===== design/jgrc_pkg.sv =====
// ----------------------------------------------------------------------------
// Relative clock package
// Shared types and constants for the jump-guarded relative clock.
// ----------------------------------------------------------------------------
package jgrc_pkg;

  localparam int unsigned SecondsWidthDefault = 32;

  localparam logic [19:0] UsecPerSec   = 20'd1000000;
  localparam logic [19:0] UsecMax      = 20'd999999;
  localparam logic [15:0] MaxJumpReset = 16'd10;

  typedef enum logic {
    OpSample = 1'b0,
    OpLoad   = 1'b1
  } operation_e;

  typedef enum logic [1:0] {
    KindNormal   = 2'd0,
    KindBackward = 2'd1,
    KindForward  = 2'd2,
    KindLoad     = 2'd3
  } jump_kind_e;

  typedef struct packed {
    logic        operation;
    logic [31:0] seconds;
    logic [19:0] microseconds;
  } in_word_t;

  typedef struct packed {
    logic [31:0] rel_seconds;
    logic [19:0] rel_microseconds;
    jump_kind_e  jump_kind;
  } out_word_t;

endpackage

// ===== design/jgrc_in_stage.sv =====
// ----------------------------------------------------------------------------
// Input stage
// Registers one incoming word and holds it until the step logic takes it.
// ----------------------------------------------------------------------------
module jgrc_in_stage import jgrc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  in_word_t in_word_i,
  input  logic     advance_i,
  output logic     valid_o,
  output in_word_t word_o
);

  logic     valid_q;
  in_word_t word_q;

  assign in_ready_o = !valid_q || advance_i;
  assign valid_o    = valid_q;
  assign word_o     = word_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      word_q <= in_word_i;
    end
  end

endmodule

// ===== design/jgrc_step.sv =====
// ----------------------------------------------------------------------------
// Step logic
// Computes the next clock state and the result word for one input word.
// ----------------------------------------------------------------------------
module jgrc_step import jgrc_pkg::*; #(
  parameter int unsigned SecondsWidth = SecondsWidthDefault
) (
  input  in_word_t                word_i,
  input  logic [15:0]             max_jump_i,
  input  logic                    primed_i,
  input  logic [SecondsWidth-1:0] prev_sec_i,
  input  logic [19:0]             prev_usec_i,
  input  logic [SecondsWidth-1:0] rel_sec_i,
  input  logic [19:0]             rel_usec_i,
  output logic                    primed_o,
  output logic                    prev_upd_o,
  output logic [SecondsWidth-1:0] sec_o,
  output logic [19:0]             usec_o,
  output logic [SecondsWidth-1:0] rel_sec_o,
  output logic [19:0]             rel_usec_o,
  output out_word_t               word_o
);

  logic [SecondsWidth-1:0] sec;
  logic [19:0]             usec;
  logic                    earlier;
  logic                    borrow;
  logic [SecondsWidth-1:0] dsec;
  logic [19:0]             dusec;
  logic                    too_far;
  logic [20:0]             usum;
  logic                    carry;
  logic [19:0]             unorm;
  logic [SecondsWidth-1:0] ssum;
  jump_kind_e              kind;

  always_comb begin
    sec     = SecondsWidth'(word_i.seconds);
    usec    = (word_i.microseconds > UsecMax) ? UsecMax : word_i.microseconds;
    borrow  = usec < prev_usec_i;
    earlier = (sec < prev_sec_i) || ((sec == prev_sec_i) && borrow);
    dsec    = sec - prev_sec_i - SecondsWidth'(borrow);
    dusec   = borrow ? (usec + UsecPerSec - prev_usec_i) : (usec - prev_usec_i);
    too_far = dsec > SecondsWidth'(max_jump_i);
    usum    = {1'b0, rel_usec_i} + {1'b0, dusec};
    carry   = usum >= {1'b0, UsecPerSec};
    unorm   = carry ? 20'(usum - {1'b0, UsecPerSec}) : usum[19:0];
    ssum    = rel_sec_i + dsec + SecondsWidth'(carry);

    primed_o   = primed_i;
    prev_upd_o = 1'b0;
    rel_sec_o  = rel_sec_i;
    rel_usec_o = rel_usec_i;
    kind       = KindNormal;

    if (word_i.operation == OpLoad) begin
      rel_sec_o  = sec;
      rel_usec_o = usec;
      kind       = KindLoad;
    end else if (!primed_i) begin
      primed_o   = 1'b1;
      prev_upd_o = 1'b1;
      rel_sec_o  = sec;
      rel_usec_o = usec;
      kind       = KindLoad;
    end else begin
      prev_upd_o = 1'b1;
      if (earlier || too_far) begin
        rel_sec_o  = rel_sec_i + SecondsWidth'(1);
        rel_usec_o = '0;
        kind       = earlier ? KindBackward : KindForward;
      end else begin
        rel_sec_o  = ssum;
        rel_usec_o = unorm;
      end
    end

    sec_o                   = sec;
    usec_o                  = usec;
    word_o.rel_seconds      = 32'(rel_sec_o);
    word_o.rel_microseconds = rel_usec_o;
    word_o.jump_kind        = kind;
  end

endmodule

// ===== design/jgrc_out_stage.sv =====
// ----------------------------------------------------------------------------
// Output stage
// Holds one result word until the consumer takes it.
// ----------------------------------------------------------------------------
module jgrc_out_stage import jgrc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      load_i,
  input  out_word_t word_i,
  output logic      advance_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_word_t out_word_o
);

  logic      valid_q;
  out_word_t word_q;

  assign advance_o   = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_word_o  = word_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (advance_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_o && load_i) begin
      word_q <= word_i;
    end
  end

endmodule

// ===== design/jump_guarded_relative_clock.sv =====
// A word accepted into the input register passes through the step logic into
// the result register, which drives the output.
// Throughput: one word per cycle while results are taken; the step logic
// between the input and result registers carries each word's state update.
// Reset clears the clock state, the primed flag and both stage valids, and
// sets the jump limit to ten seconds. The configuration port is always ready.
// ----------------------------------------------------------------------------
// Jump-guarded relative clock
// Keeps a relative clock from wall-clock samples, monotonic between load words,
// stepping by one second on backward or oversized forward jumps.
// ----------------------------------------------------------------------------
module jump_guarded_relative_clock import jgrc_pkg::*; #(
  parameter int unsigned SecondsWidth = SecondsWidthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_word_t    in_word_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_word_t   out_word_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i
);

  logic                    stage_valid;
  in_word_t                stage_word;
  logic                    advance;
  logic                    fire;
  logic [15:0]             max_jump_q;
  logic                    primed_q, primed_d;
  logic [SecondsWidth-1:0] prev_sec_q;
  logic [19:0]             prev_usec_q;
  logic [SecondsWidth-1:0] rel_sec_q, rel_sec_d;
  logic [19:0]             rel_usec_q, rel_usec_d;
  logic                    prev_upd;
  logic [SecondsWidth-1:0] sec_d;
  logic [19:0]             usec_d;
  out_word_t               step_word;

  assign cfg_ready_o = 1'b1;
  assign fire        = stage_valid && advance;

  jgrc_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_word_i  (in_word_i),
    .advance_i  (advance),
    .valid_o    (stage_valid),
    .word_o     (stage_word)
  );

  jgrc_step #(
    .SecondsWidth (SecondsWidth)
  ) u_step (
    .word_i      (stage_word),
    .max_jump_i  (max_jump_q),
    .primed_i    (primed_q),
    .prev_sec_i  (prev_sec_q),
    .prev_usec_i (prev_usec_q),
    .rel_sec_i   (rel_sec_q),
    .rel_usec_i  (rel_usec_q),
    .primed_o    (primed_d),
    .prev_upd_o  (prev_upd),
    .sec_o       (sec_d),
    .usec_o      (usec_d),
    .rel_sec_o   (rel_sec_d),
    .rel_usec_o  (rel_usec_d),
    .word_o      (step_word)
  );

  jgrc_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (stage_valid),
    .word_i      (step_word),
    .advance_o   (advance),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_jump_q <= MaxJumpReset;
    end else if (cfg_valid_i) begin
      max_jump_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      primed_q    <= 1'b0;
      prev_sec_q  <= '0;
      prev_usec_q <= '0;
      rel_sec_q   <= '0;
      rel_usec_q  <= '0;
    end else if (fire) begin
      primed_q   <= primed_d;
      rel_sec_q  <= rel_sec_d;
      rel_usec_q <= rel_usec_d;
      if (prev_upd) begin
        prev_sec_q  <= sec_d;
        prev_usec_q <= usec_d;
      end
    end
  end

endmodule

// ===== design/jgrc_checker.sv =====
// ----------------------------------------------------------------------------
// Relative clock checker
// Port-level checks on the result channel and the input ready, bound to the top level.
// ----------------------------------------------------------------------------
module jgrc_checker import jgrc_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input out_word_t   out_word_o
);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("Result word dropped while stalled.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_word_o.rel_microseconds <= UsecMax)
    else $error("Relative microseconds out of range.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_word_o.jump_kind == KindBackward ||
                    out_word_o.jump_kind == KindForward)
      |-> out_word_o.rel_microseconds == '0)
    else $error("Jump step did not clear microseconds.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("Input blocked without a stalled result.");

endmodule

bind jump_guarded_relative_clock jgrc_checker u_jgrc_checker (.*);

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Relative clock testbench
// Drives sample and load words into the jump-guarded relative clock under
// random valid and ready gaps, and moves the jump limit between phases. A
// built-in copy of the clock logic predicts every result word, and the
// monitor checks each field as the words come out.
// ----------------------------------------------------------------------------
module testbench;
  import jgrc_pkg::*;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned WordsPerPhase = 283;
  localparam int unsigned Phases = 6;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  in_word_t    in_word_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  out_word_t   out_word_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [15:0] cfg_data_i = '0;

  in_word_t    pending_words[$];
  logic [15:0] pending_limits[$];
  out_word_t   expected_times[$];
  out_word_t   due_time;

  logic [31:0] prev_sec = '0;
  logic [19:0] prev_usec = '0;
  logic [31:0] rel_sec = '0;
  logic [19:0] rel_usec = '0;
  logic        primed = 1'b0;
  logic [15:0] jump_limit = MaxJumpReset;

  logic [31:0] wall_sec = 32'd1;
  logic [15:0] limit_plan [Phases];

  int unsigned cycle_count = 0;
  int unsigned fail_count = 0;
  logic        calm;

  jump_guarded_relative_clock u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_word_i  (in_word_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_word_o (out_word_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i)
  );

  always #2 clk_i = ~clk_i;

  assign calm = (cycle_count >= 1200) && (cycle_count < 1800);

  function automatic logic [19:0] clamp_usec(logic [19:0] usec);
    return (usec > UsecMax) ? UsecMax : usec;
  endfunction

  function automatic out_word_t advance_clock(in_word_t w);
    logic [19:0] usec;
    logic [31:0] dsec;
    logic [20:0] dusec;
    logic [20:0] usum;
    jump_kind_e  kind;
    out_word_t   r;
    usec = clamp_usec(w.microseconds);
    if (w.operation == OpLoad) begin
      rel_sec = w.seconds;
      rel_usec = usec;
      kind = KindLoad;
    end else if (!primed) begin
      prev_sec = w.seconds;
      prev_usec = usec;
      rel_sec = w.seconds;
      rel_usec = usec;
      primed = 1'b1;
      kind = KindLoad;
    end else begin
      if (w.seconds < prev_sec || (w.seconds == prev_sec && usec < prev_usec)) begin
        rel_sec = rel_sec + 32'd1;
        rel_usec = '0;
        kind = KindBackward;
      end else begin
        dsec = w.seconds - prev_sec;
        if (usec >= prev_usec) begin
          dusec = 21'(usec) - 21'(prev_usec);
        end else begin
          dusec = 21'(usec) + 21'(UsecPerSec) - 21'(prev_usec);
          dsec = dsec - 32'd1;
        end
        if (dsec > 32'(jump_limit)) begin
          rel_sec = rel_sec + 32'd1;
          rel_usec = '0;
          kind = KindForward;
        end else begin
          usum = 21'(rel_usec) + dusec;
          rel_sec = rel_sec + dsec;
          if (usum >= 21'(UsecPerSec)) begin
            usum = usum - 21'(UsecPerSec);
            rel_sec = rel_sec + 32'd1;
          end
          rel_usec = usum[19:0];
          kind = KindNormal;
        end
      end
      prev_sec = w.seconds;
      prev_usec = usec;
    end
    r.rel_seconds = rel_sec;
    r.rel_microseconds = rel_usec;
    r.jump_kind = kind;
    return r;
  endfunction

  function automatic in_word_t pack_word(operation_e op, logic [31:0] sec, logic [19:0] usec);
    in_word_t w;
    w.operation = op;
    w.seconds = sec;
    w.microseconds = usec;
    return w;
  endfunction

  // Mostly forward samples around the jump limit, with loads, backward and
  // oversized jumps, and some fully random words mixed in.
  function automatic in_word_t next_stimulus(int unsigned limit);
    in_word_t    w;
    int unsigned pick;
    logic [31:0] step;
    pick = $urandom_range(99);
    w.operation = OpSample;
    w.seconds = $urandom;
    w.microseconds = 20'($urandom_range(20'hFFFFF));
    if (pick < 8) begin
      w.operation = OpLoad;
      if ($urandom_range(3) == 0) begin
        w.seconds = 32'hFFFFFFFF - 32'($urandom_range(3));
      end
      return w;
    end else if (pick < 26 && pick >= 16) begin
      w.seconds = wall_sec - 32'($urandom_range(3));
      w.microseconds = 20'($urandom_range(UsecMax));
    end else if (pick < 34 && pick >= 26) begin
      w.seconds = wall_sec + 32'(limit) + 32'd1 + 32'($urandom_range(5));
      w.microseconds = 20'($urandom_range(UsecMax));
    end else if (pick >= 34) begin
      step = 32'($urandom_range(limit + 1));
      if ($urandom_range(3) == 0) begin
        step = 32'(limit) + 32'($urandom_range(1));
      end
      w.seconds = wall_sec + step;
      if ($urandom_range(19) != 0) begin
        w.microseconds = 20'($urandom_range(UsecMax));
      end
    end
    wall_sec = w.seconds;
    return w;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      fail_count++;
      if (fail_count <= 10) begin
        $display("Mismatch in %s: expected %0h, got %0h", name, want, got);
      end
    end
  endtask

  task automatic drain_words();
    while (pending_words.size() != 0 || in_valid_i || expected_times.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      cfg_valid_i <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        jump_limit = cfg_data_i;
      end
      if (in_valid_i && in_ready_o) begin
        expected_times.push_back(advance_clock(in_word_i));
      end
      if (!in_valid_i || in_ready_o) begin
        if (pending_words.size() != 0 && (calm || $urandom_range(99) >= 29)) begin
          in_valid_i <= 1'b1;
          in_word_i <= pending_words.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      if (!cfg_valid_i || cfg_ready_o) begin
        if (pending_limits.size() != 0) begin
          cfg_valid_i <= 1'b1;
          cfg_data_i <= pending_limits.pop_front();
        end else begin
          cfg_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expected_times.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("Unexpected result word %0h", out_word_o);
          end
        end else begin
          due_time = expected_times.pop_front();
          check_field("rel_seconds", due_time.rel_seconds, out_word_o.rel_seconds);
          check_field("rel_microseconds", 32'(due_time.rel_microseconds),
                      32'(out_word_o.rel_microseconds));
          check_field("jump_kind", 32'(due_time.jump_kind), 32'(out_word_o.jump_kind));
        end
      end
      out_ready_i <= calm || ($urandom_range(99) >= 29);
    end
  end

  initial begin
    limit_plan[0] = MaxJumpReset;
    limit_plan[1] = 16'd0;
    limit_plan[2] = 16'hFFFF;
    limit_plan[3] = 16'd1;
    limit_plan[4] = 16'($urandom_range(2, 4000));
    limit_plan[5] = 16'd3;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    for (int p = 0; p < Phases; p++) begin
      if (p != 0) begin
        drain_words();
        repeat (4) @(posedge clk_i);
        @(negedge clk_i);
        pending_limits.push_back(limit_plan[p]);
        while (pending_limits.size() != 0 || cfg_valid_i) begin
          @(posedge clk_i);
        end
      end
      @(negedge clk_i);
      if (p == 0) begin
        pending_words.push_back(pack_word(OpLoad, 32'd5, 20'd7));
        pending_words.push_back(pack_word(OpSample, 32'd100, 20'd500000));
        pending_words.push_back(pack_word(OpSample, 32'd100, 20'd500000));
        pending_words.push_back(pack_word(OpSample, 32'd100, 20'hFFFFF));
        pending_words.push_back(pack_word(OpSample, 32'd101, 20'd0));
        pending_words.push_back(pack_word(OpSample, 32'd111, 20'd0));
        pending_words.push_back(pack_word(OpSample, 32'd122, 20'd5));
        pending_words.push_back(pack_word(OpSample, 32'd133, 20'd4));
        pending_words.push_back(pack_word(OpSample, 32'd133, 20'd3));
        pending_words.push_back(pack_word(OpSample, 32'd0, 20'd0));
        pending_words.push_back(pack_word(OpSample, 32'hFFFFFFFF, UsecMax));
        pending_words.push_back(pack_word(OpSample, 32'hFFFFFFFF, UsecMax));
        pending_words.push_back(pack_word(OpLoad, 32'hFFFFFFFF, 20'd500000));
        pending_words.push_back(pack_word(OpSample, 32'd0, 20'd0));
        pending_words.push_back(pack_word(OpLoad, 32'hFFFFFFFE, UsecMax));
        pending_words.push_back(pack_word(OpSample, 32'd1, 20'd1));
        pending_words.push_back(pack_word(OpLoad, 32'd7, UsecPerSec));
        pending_words.push_back(pack_word(OpLoad, 32'hFFFFFFFF, 20'hFFFFF));
        pending_words.push_back(pack_word(OpSample, 32'hAAAAAAAA, 20'h55555));
        pending_words.push_back(pack_word(OpSample, 32'h55555555, 20'hAAAAA));
        pending_words.push_back(pack_word(OpLoad, 32'd0, 20'd0));
        wall_sec = 32'h55555555;
      end
      repeat (WordsPerPhase) pending_words.push_back(next_stimulus(limit_plan[p]));
    end
    drain_words();
    repeat (8) @(posedge clk_i);
    if (fail_count == 0 && expected_times.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/jgrc_pkg.sv
design/jgrc_in_stage.sv
design/jgrc_step.sv
design/jgrc_out_stage.sv
design/jump_guarded_relative_clock.sv
design/jgrc_checker.sv
verif/testbench.sv
